// ----- hdl/mrrs_pkg.sv -----
// ----------------------------------------------------------------------------
// mrrs_pkg
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// read-holding-registers slave.
// ----------------------------------------------------------------------------
`default_nettype none

package mrrs_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int FRAME_W     = 3;

  localparam logic [7:0]  FC_READ  = 8'h03;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // configuration register indexes
  localparam logic CFG_STATION_ADDR = 1'b0;
  localparam logic CFG_CRC_CHECK    = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_EVAL,
    S_HDR_ADDR,
    S_HDR_FUNC,
    S_HDR_BCNT,
    S_RD,
    S_DHI,
    S_DLO,
    S_CRC_LO,
    S_CRC_HI
  } state_t;

  // source of the byte loaded into the output register
  typedef enum logic [2:0] {
    SRC_ADDR,
    SRC_FUNC,
    SRC_BCNT,
    SRC_HI,
    SRC_LO,
    SRC_CRC_LO,
    SRC_CRC_HI
  } src_t;

  typedef struct packed {
    logic take_byte;
    logic take_write;
    logic chk_start;
    logic chk_step;
    logic load_req;
    logic emit;
    src_t src;
    logic rd_issue;
    logic cnt_inc;
  } cmd_t;

  typedef struct packed {
    logic fill_last;
    logic chk_last;
    logic req_ok;
    logic qty_zero;
    logic word_last;
    logic out_free;
  } sts_t;

  // CRC-16/Modbus, one byte, reflected
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/mrrs_in_if.sv -----
// ----------------------------------------------------------------------------
// mrrs_in_if
// Request channel: received line bytes and holding register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrrs_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  rx_byte;
  logic [3:0]  reg_index;
  logic [15:0] reg_value;

  modport source (output valid, command, rx_byte, reg_index, reg_value,
                  input ready);
  modport sink   (input valid, command, rx_byte, reg_index, reg_value,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/mrrs_out_if.sv -----
// ----------------------------------------------------------------------------
// mrrs_out_if
// Response channel: one response byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrrs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_byte;

  modport source (output valid, tx_byte, last_byte, input ready);
  modport sink   (input valid, tx_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/mrrs_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrrs_ctrl
// Sequencer: collects the request, runs the CRC check, validates and walks
// the response frame one byte at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_command,
  output logic               in_ready,
  input  wire mrrs_pkg::sts_t sts,
  output mrrs_pkg::cmd_t     cmd
);
  import mrrs_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !in_command && sts.fill_last) state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.chk_last) state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = sts.req_ok ? S_HDR_ADDR : S_IDLE;
      end
      S_HDR_ADDR: begin
        if (sts.out_free) state_next = S_HDR_FUNC;
      end
      S_HDR_FUNC: begin
        if (sts.out_free) state_next = S_HDR_BCNT;
      end
      S_HDR_BCNT: begin
        if (sts.out_free) state_next = sts.qty_zero ? S_CRC_LO : S_RD;
      end
      S_RD: begin
        state_next = S_DHI;
      end
      S_DHI: begin
        if (sts.out_free) state_next = S_DLO;
      end
      S_DLO: begin
        if (sts.out_free) state_next = sts.word_last ? S_CRC_LO : S_RD;
      end
      S_CRC_LO: begin
        if (sts.out_free) state_next = S_CRC_HI;
      end
      S_CRC_HI: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.src        = SRC_ADDR;
    cmd.take_byte  = accept && !in_command;
    cmd.take_write = accept && in_command;
    case (state)
      S_IDLE: begin
        cmd.chk_start = accept && !in_command && sts.fill_last;
      end
      S_CHK: begin
        cmd.chk_step = 1'b1;
      end
      S_EVAL: begin
        cmd.load_req = 1'b1;
      end
      S_HDR_ADDR: begin
        cmd.emit = sts.out_free;
        cmd.src  = SRC_ADDR;
      end
      S_HDR_FUNC: begin
        cmd.emit = sts.out_free;
        cmd.src  = SRC_FUNC;
      end
      S_HDR_BCNT: begin
        cmd.emit = sts.out_free;
        cmd.src  = SRC_BCNT;
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
      end
      S_DHI: begin
        cmd.emit = sts.out_free;
        cmd.src  = SRC_HI;
      end
      S_DLO: begin
        cmd.emit    = sts.out_free;
        cmd.src     = SRC_LO;
        cmd.cnt_inc = sts.out_free;
      end
      S_CRC_LO: begin
        cmd.emit = sts.out_free;
        cmd.src  = SRC_CRC_LO;
      end
      S_CRC_HI: begin
        cmd.emit = sts.out_free;
        cmd.src  = SRC_CRC_HI;
      end
      default: begin
        cmd.emit = 1'b0;
      end
    endcase
  end

`ifndef SYNTH
  // a byte is only loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("emit while output register busy");

  // a rejected request returns to collecting
  a_reject_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && !sts.req_ok) |=> in_ready)
    else $error("rejected request did not return to idle");
`endif

endmodule

`default_nettype wire

// ----- hdl/mrrs_dp.sv -----
// ----------------------------------------------------------------------------
// mrrs_dp
// Datapath: request frame store, CRC units, request decode, holding
// register memory and the response output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrs_dp #(
  parameter int REG_COUNT = 16,
  parameter int MAX_READ  = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire mrrs_pkg::cmd_t cmd,
  output mrrs_pkg::sts_t      sts,
  input  wire logic [7:0]     station_addr,
  input  wire logic           crc_check_enable,
  input  wire logic [7:0]     rx_byte,
  input  wire logic [3:0]     reg_index,
  input  wire logic [15:0]    reg_value,
  input  wire logic           out_ready,
  output logic                out_valid,
  output logic [7:0]          tx_byte,
  output logic                last_byte
);
  import mrrs_pkg::*;

  localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int CNT_W = $clog2(MAX_READ + 1);

  logic [7:0]         frame [FRAME_BYTES];
  logic [FRAME_W-1:0] fill;
  logic [FRAME_W-1:0] ptr;
  logic [15:0]        chk_crc;
  logic [15:0]        crc;
  logic [IDX_W-1:0]   start_q;
  logic [CNT_W-1:0]   qty_q;
  logic [CNT_W-1:0]   cnt;

  logic [15:0]          mem [REG_COUNT];
  logic [REG_COUNT-1:0] vbits;
  logic [15:0]          rd_data;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     wr_addr;
  logic                 wr_ok;

  logic [15:0] start_w;
  logic [15:0] qty_w;
  logic [16:0] end_sum;
  logic        crc_ok;
  logic [15:0] word;
  logic [7:0]  byte_sel;

  // ---- request frame ----
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.take_byte) begin
      fill <= fill + FRAME_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      frame[fill] <= rx_byte;
    end
  end

  // CRC over bytes 0..5, one byte a cycle
  always_ff @(posedge clk) begin
    if (cmd.chk_start) begin
      ptr     <= '0;
      chk_crc <= CRC_INIT;
    end else if (cmd.chk_step) begin
      ptr     <= ptr + FRAME_W'(1);
      chk_crc <= crc_update(chk_crc, frame[ptr]);
    end
  end

  assign start_w = {frame[2], frame[3]};
  assign qty_w   = {frame[4], frame[5]};
  assign end_sum = {1'b0, start_w} + {1'b0, qty_w};
  assign crc_ok  = !crc_check_enable ||
                   (chk_crc == {frame[FRAME_BYTES-1], frame[FRAME_BYTES-2]});

  // ---- response sequencing registers ----
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      start_q <= IDX_W'(start_w);
      qty_q   <= CNT_W'(qty_w);
      cnt     <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      crc <= CRC_INIT;
    end else if (cmd.emit && cmd.src != SRC_CRC_LO && cmd.src != SRC_CRC_HI) begin
      crc <= crc_update(crc, byte_sel);
    end
  end

  // ---- holding registers ----
  assign wr_ok   = (32'(reg_index) < 32'(REG_COUNT));
  assign wr_addr = IDX_W'(reg_index);
  assign rd_addr = start_q + IDX_W'(cnt);

  always_ff @(posedge clk) begin
    if (cmd.take_write && wr_ok) begin
      mem[wr_addr] <= reg_value;
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (cmd.take_write && wr_ok) begin
      vbits[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_vld <= vbits[rd_addr];
    end
  end

  assign word = rd_vld ? rd_data : 16'h0000;

  // ---- output byte select and register ----
  always_comb begin
    case (cmd.src)
      SRC_ADDR:   byte_sel = frame[0];
      SRC_FUNC:   byte_sel = FC_READ;
      SRC_BCNT:   byte_sel = {frame[5][6:0], 1'b0};
      SRC_HI:     byte_sel = word[15:8];
      SRC_LO:     byte_sel = word[7:0];
      SRC_CRC_LO: byte_sel = crc[7:0];
      SRC_CRC_HI: byte_sel = crc[15:8];
      default:    byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      tx_byte   <= byte_sel;
      last_byte <= (cmd.src == SRC_CRC_HI);
    end
  end

  // ---- status ----
  always_comb begin
    sts.fill_last = (fill == FRAME_W'(FRAME_BYTES - 1));
    sts.chk_last  = (ptr == FRAME_W'(FRAME_BYTES - 3));
    sts.req_ok    = crc_ok && (frame[0] == station_addr) && (frame[1] == FC_READ) &&
                    (qty_w <= 16'(MAX_READ)) && (end_sum <= 17'(REG_COUNT));
    sts.qty_zero  = (qty_q == '0);
    sts.word_last = ((cnt + CNT_W'(1)) == qty_q);
    sts.out_free  = !out_valid || out_ready;
  end

`ifndef SYNTH
  // the final CRC byte is flagged as last on the output
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.src == SRC_CRC_HI) |=> (out_valid && last_byte))
    else $error("CRC high byte not marked last");

  // a completed frame restarts collection
  a_fill_wrap: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_byte && sts.fill_last) |=> (fill == '0))
    else $error("frame fill did not wrap");

  // register reads stay inside the store
  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_issue |-> (32'(rd_addr) < 32'(REG_COUNT)))
    else $error("register read out of range");

  // a register write leaves the frame being collected alone
  a_write_fill: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_write && !cmd.take_byte) |=> $stable(fill))
    else $error("register write disturbed frame fill");
`endif

endmodule

`default_nettype wire

// ----- hdl/modbus_rtu_read_register_slave.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_read_register_slave
// Modbus RTU slave answering read holding registers (function 0x03).
// ----------------------------------------------------------------------------
// Line bytes and register writes enter on req. The eighth byte of a
// request closes the frame; the block then stops taking beats while it
// checks the request: a CRC pass over bytes 0..5 (one byte a cycle, always
// run, only compared when crc_check_enable is set) and a decode step. A
// rejected frame then returns to idle. An accepted frame of q registers
// then emits 3 header bytes, q big-endian words and the two CRC bytes, one
// byte per cycle on rsp while rsp is ready, with a registered
// holding-register read before each word. Register values written before
// a read are returned; never-written registers read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_read_register_slave #(
  parameter int REG_COUNT = 16,
  parameter int MAX_READ  = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  mrrs_in_if.sink         req,
  mrrs_out_if.source      rsp
);
  import mrrs_pkg::*;

  logic [7:0] station_addr;
  logic       crc_check_enable;
  cmd_t       cmd;
  sts_t       sts;

  always_ff @(posedge clk) begin
    if (rst) begin
      station_addr     <= 8'h01;
      crc_check_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STATION_ADDR: station_addr     <= cfg_data;
        CFG_CRC_CHECK:    crc_check_enable <= cfg_data[0];
        default:          station_addr     <= station_addr;
      endcase
    end
  end

  mrrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_command (req.command),
    .in_ready   (req.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  mrrs_dp #(
    .REG_COUNT (REG_COUNT),
    .MAX_READ  (MAX_READ)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .station_addr     (station_addr),
    .crc_check_enable (crc_check_enable),
    .rx_byte          (req.rx_byte),
    .reg_index        (req.reg_index),
    .reg_value        (req.reg_value),
    .out_ready        (rsp.ready),
    .out_valid        (rsp.valid),
    .tx_byte          (rsp.tx_byte),
    .last_byte        (rsp.last_byte)
  );

endmodule

`default_nettype wire
